// ===== design/tbt_pkg.sv =====
`default_nettype none

package tbt_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_TRACE_ENABLE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_BASE  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_SIZE  = 2'd2;

    // halfword match patterns
    localparam logic [15:0] BX_MASK    = 16'hFF80;
    localparam logic [15:0] BX_CODE    = 16'h4700;
    localparam logic [15:0] BCOND_MASK = 16'hF000;
    localparam logic [15:0] BCOND_CODE = 16'hD000;
    localparam logic [15:0] B_MASK     = 16'hF800;
    localparam logic [15:0] B_CODE     = 16'hE000;
    localparam logic [15:0] BL_CODE    = 16'hF000;
    localparam logic [15:0] BL2_MASK   = 16'hC000;
    localparam logic [15:0] BL2_CODE   = 16'hC000;
    localparam logic [3:0]  COND_NV    = 4'hF;
    localparam logic [3:0]  RM_PC      = 4'hF;
    localparam logic [31:0] PC_AHEAD   = 32'd4;

    typedef struct packed {
        logic [31:0] pc;
        logic [3:0]  insn_size;
        logic [31:0] insn_word;
        logic        thumb_state;
        logic [31:0] rm_value;
    } t_in_item;

    typedef struct packed {
        logic        traced;
        logic        br_hit;
        logic [31:0] br_addr;
        logic        target_thumb;
        logic [6:0]  trace_count;
        logic        last_valid;
        logic [31:0] last_branch_pc;
        logic [31:0] last_target_addr;
        logic        last_branch_thumb;
    } t_out_item;

    typedef struct packed {
        logic        br_hit;
        logic [31:0] target;
        logic        thumb;
    } t_branch;

endpackage

`default_nettype wire

// ===== design/tbt_decode.sv =====
`default_nettype none

module tbt_decode (
    input  var tbt_pkg::t_in_item i_item,
    output var tbt_pkg::t_branch  o_branch
);
    import tbt_pkg::*;

    logic        sz_one;
    logic        sz_short;
    logic [15:0] hw0;
    logic [15:0] hw1;
    logic [31:0] pc4;
    logic        s_bit;
    logic        i1;
    logic        i2;
    logic [31:0] imm_bcond;
    logic [31:0] imm_b;
    logic [31:0] imm_bl;
    logic [31:0] sum_bcond;
    logic [31:0] sum_b;
    logic [31:0] sum_bl;
    logic        hit_bx;
    logic        hit_bcond;
    logic        hit_b;
    logic        hit_bl;

    // size zero counts as eight
    assign sz_one   = (i_item.insn_size == 4'd1);
    assign sz_short = (i_item.insn_size == 4'd1) || (i_item.insn_size == 4'd2) ||
                      (i_item.insn_size == 4'd3);

    assign hw0 = sz_one ? {8'h00, i_item.insn_word[7:0]} : i_item.insn_word[15:0];
    assign hw1 = i_item.insn_word[31:16];
    assign pc4 = i_item.pc + PC_AHEAD;

    assign s_bit = hw0[10];
    assign i1    = ~(hw1[13] ^ s_bit);
    assign i2    = ~(hw1[11] ^ s_bit);

    assign imm_bcond = {{23{hw0[7]}}, hw0[7:0], 1'b0};
    assign imm_b     = {{20{hw0[10]}}, hw0[10:0], 1'b0};
    assign imm_bl    = {{7{s_bit}}, s_bit, i1, i2, hw0[9:0], hw1[10:0], 1'b0};

    assign sum_bcond = pc4 + imm_bcond;
    assign sum_b     = pc4 + imm_b;
    assign sum_bl    = pc4 + imm_bl;

    assign hit_bx    = i_item.thumb_state && ((hw0 & BX_MASK) == BX_CODE);
    assign hit_bcond = i_item.thumb_state && !sz_one &&
                       ((hw0 & BCOND_MASK) == BCOND_CODE) && (hw0[11:8] != COND_NV);
    assign hit_b     = i_item.thumb_state && !sz_one && ((hw0 & B_MASK) == B_CODE);
    assign hit_bl    = i_item.thumb_state && !sz_short && ((hw0 & B_MASK) == BL_CODE) &&
                       ((hw1 & BL2_MASK) == BL2_CODE);

    always_comb begin
        o_branch = '0;
        if (hit_bx) begin
            o_branch.br_hit = 1'b1;
            o_branch.target = (hw0[6:3] == RM_PC) ? pc4 : i_item.rm_value;
            o_branch.thumb  = o_branch.target[0];
        end else if (hit_bcond) begin
            o_branch.br_hit = 1'b1;
            o_branch.target = {sum_bcond[31:1], 1'b1};
            o_branch.thumb  = 1'b1;
        end else if (hit_b) begin
            o_branch.br_hit = 1'b1;
            o_branch.target = {sum_b[31:1], 1'b1};
            o_branch.thumb  = 1'b1;
        end else if (hit_bl) begin
            o_branch.br_hit = 1'b1;
            if (hw1[12]) begin
                o_branch.target = {sum_bl[31:1], 1'b1};
                o_branch.thumb  = 1'b1;
            end else begin
                // blx switches to arm, word aligned
                o_branch.target = {sum_bl[31:2], 2'b00};
                o_branch.thumb  = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/thumb_branch_trace_unit.sv =====
// Branch trace unit for a Thumb-capable core.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one retired
// instruction per request: pc, byte count, code word, Thumb bit, Rm value.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// result per request: traced and branch flags, branch target with its Thumb
// state, the saturating trace count and the last-branch record after this
// instruction.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// writes trace enable, window base and window size; it is always ready. It must
// be written only while no request is in flight; the block does not enforce it.
// A request is held in the input register, then window check, decode and
// record update load the result register. Throughput is one request per cycle
// with the receiver ready.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; input ready drops after that.
// Reset clears the configuration, the trace count and the last-branch record
// and empties both registers.
`default_nettype none

module thumb_branch_trace_unit #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_in_valid,
    output var logic                          o_in_ready,
    input  var tbt_pkg::t_in_item             i_in_data,
    output var logic                          o_out_valid,
    input  var logic                          i_out_ready,
    output var tbt_pkg::t_out_item            o_out_data,
    input  var logic                          i_cfg_valid,
    output var logic                          o_cfg_ready,
    input  var logic [tbt_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  var logic [31:0]                   i_cfg_data
);
    import tbt_pkg::*;

    localparam int unsigned CntW = $clog2(RING_DEPTH + 1);

    logic            r_enable;
    logic [31:0]     r_base;
    logic [31:0]     r_size;
    logic            r_in_valid;
    t_in_item        r_in;
    logic            r_out_valid;
    t_out_item       r_out;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_last_valid;
    logic [31:0]     r_last_pc;
    logic [31:0]     r_last_target;
    logic            r_last_thumb;

    logic            out_load;
    logic            in_take;
    logic            in_window;
    logic [31:0]     pc_offset;
    logic            traced;
    t_branch         dec;
    logic            take_branch;
    logic [CntW+6:0] count_ext;
    t_out_item       n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_base   <= '0;
            r_size   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRACE_ENABLE: r_enable <= i_cfg_data[0];
                CFG_WINDOW_BASE:  r_base   <= i_cfg_data;
                CFG_WINDOW_SIZE:  r_size   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    assign out_load   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || out_load;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !out_load);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    tbt_decode u_decode (
        .i_item   (r_in),
        .o_branch (dec)
    );

    assign pc_offset   = r_in.pc - r_base;
    assign in_window   = (r_base != '0) && (r_size != '0) && (r_in.pc >= r_base) &&
                         (pc_offset < r_size);
    assign traced      = r_enable && in_window;
    assign take_branch = traced && dec.br_hit;

    always_comb begin
        n_count = r_count;
        if (traced && (r_count < CntW'(RING_DEPTH))) begin
            n_count = r_count + CntW'(1);
        end
    end

    assign count_ext = {7'd0, n_count};

    always_comb begin
        n_out                   = '0;
        n_out.traced            = traced;
        n_out.br_hit            = take_branch;
        n_out.br_addr           = take_branch ? dec.target : '0;
        n_out.target_thumb      = take_branch && dec.thumb;
        n_out.trace_count       = count_ext[6:0];
        n_out.last_valid        = take_branch || r_last_valid;
        n_out.last_branch_pc    = take_branch ? r_in.pc : r_last_pc;
        n_out.last_target_addr  = take_branch ? dec.target : r_last_target;
        n_out.last_branch_thumb = take_branch ? dec.thumb : r_last_thumb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_last_valid  <= 1'b0;
            r_last_pc     <= '0;
            r_last_target <= '0;
            r_last_thumb  <= 1'b0;
        end else if (out_load) begin
            r_count       <= n_count;
            r_last_valid  <= n_out.last_valid;
            r_last_pc     <= n_out.last_branch_pc;
            r_last_target <= n_out.last_target_addr;
            r_last_thumb  <= n_out.last_branch_thumb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/tbt_checker.sv =====
`default_nettype none

module tbt_checker #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_in_valid,
    input  var logic                          o_in_ready,
    input  var tbt_pkg::t_in_item             i_in_data,
    input  var logic                          o_out_valid,
    input  var logic                          i_out_ready,
    input  var tbt_pkg::t_out_item            o_out_data,
    input  var logic                          i_cfg_valid,
    input  var logic                          o_cfg_ready,
    input  var logic [tbt_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  var logic [31:0]                   i_cfg_data
);
    import tbt_pkg::*;

    localparam logic [7:0] DepthCap = (RING_DEPTH > 127) ? 8'd127 : 8'(RING_DEPTH);

    logic unused_ok;
    assign unused_ok = ^{i_in_valid, o_in_ready, i_in_data, i_cfg_valid, o_cfg_ready,
                         i_cfg_index, i_cfg_data};

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // nothing valid right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_untraced_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.traced) |->
        (!o_out_data.br_hit && (o_out_data.br_addr == '0) &&
         !o_out_data.target_thumb))
        else $error("untraced request reports a branch");

    a_record_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.br_hit) |->
        (o_out_data.last_valid &&
         (o_out_data.last_target_addr == o_out_data.br_addr) &&
         (o_out_data.last_branch_thumb == o_out_data.target_thumb)))
        else $error("last-branch record does not match branch");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((RING_DEPTH > 127) ||
                         ({1'b0, o_out_data.trace_count} <= DepthCap)))
        else $error("trace count above ring depth");

endmodule

bind thumb_branch_trace_unit tbt_checker #(.RING_DEPTH(RING_DEPTH)) u_tbt_checker (.*);

`default_nettype wire
